FILE: src/i2cms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types and constants shared by the I2C master bus sequencer modules.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // Bus primitive codes as they arrive on the input channel
  typedef enum logic [2:0] {
    FUNC_START      = 3'd0,
    FUNC_STOP       = 3'd1,
    FUNC_SEND_BYTE  = 3'd2,
    FUNC_RECV_BYTE  = 3'd3,
    FUNC_WRITE_ADDR = 3'd4,
    FUNC_READ_ADDR  = 3'd5
  } func_e;

  // Classified operation handed from the front end to the back end
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_SEND  = 2'd2,
    OP_RECV  = 2'd3
  } op_e;

  // Back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_STOP,
    ST_TX_BITS,
    ST_TX_ACK,
    ST_RX_REL,
    ST_RX_BITS,
    ST_RX_TAIL
  } state_e;

  localparam logic [7:0] ADDR_WRITE = 8'hA0;
  localparam logic [7:0] ADDR_READ  = 8'hA1;
  localparam int unsigned DevSelW   = 3;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       ack_after;
    logic [7:0] device_byte;
    logic       device_ack_level;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       sample_taken;
    logic [7:0] rx_data;
    logic       ack_seen;
    logic       last;
  } result_t;

  // One queued command: data is the byte to send, or the slave's receive bits
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       ack_after;
    logic       dev_ack;
  } cmd_t;

endpackage

`default_nettype wire

FILE: src/i2cms_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_front
// Accepts primitives, resolves address bytes, and queues commands (2 deep).
// ----------------------------------------------------------------------------
module i2cms_front import i2cms_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire item_t              in_data_i,
  input  wire logic               cfg_we_i,
  input  wire logic [DevSelW-1:0] cfg_data_i,
  output      logic               cmd_valid_o,
  output      cmd_t               cmd_o,
  input  wire logic               cmd_pop_i
);

  logic [DevSelW-1:0] dev_sel_q;
  cmd_t               mem_q [2];
  logic               wr_q, rd_q;
  logic [1:0]         cnt_q;
  cmd_t               cmd_new;
  logic               known;
  logic               push;
  logic [7:0]         addr_off;

  assign addr_off = {4'b0000, dev_sel_q, 1'b0};

  // Classify the primitive; undefined codes are consumed and dropped
  always_comb begin
    cmd_new.op        = OP_START;
    cmd_new.data      = in_data_i.tx_byte;
    cmd_new.ack_after = in_data_i.ack_after;
    cmd_new.dev_ack   = in_data_i.device_ack_level;
    known             = 1'b1;
    unique case (in_data_i.func)
      FUNC_START:      cmd_new.op = OP_START;
      FUNC_STOP:       cmd_new.op = OP_STOP;
      FUNC_SEND_BYTE:  cmd_new.op = OP_SEND;
      FUNC_RECV_BYTE: begin
        cmd_new.op   = OP_RECV;
        cmd_new.data = in_data_i.device_byte;
      end
      FUNC_WRITE_ADDR: begin
        cmd_new.op   = OP_SEND;
        cmd_new.data = ADDR_WRITE + addr_off;
      end
      FUNC_READ_ADDR: begin
        cmd_new.op   = OP_SEND;
        cmd_new.data = ADDR_READ + addr_off;
      end
      default:         known = 1'b0;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o && known;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_sel_q <= '0;
      wr_q      <= 1'b0;
      rd_q      <= 1'b0;
      cnt_q     <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        dev_sel_q <= cfg_data_i;
      end
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (cmd_pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

FILE: src/i2cms_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_back
// Pin sequencer: one SCL/SDA write per cycle, while the result side takes them, into a registered result.
// ----------------------------------------------------------------------------
module i2cms_back import i2cms_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    cmd_valid_i,
  input  wire cmd_t    cmd_i,
  output      logic    cmd_pop_o,
  output      logic    out_valid_o,
  input  wire logic    out_ready_i,
  output      result_t out_data_o
);

  state_e     state_q, state_d;
  logic       scl_q, scl_d, sda_q, sda_d, drv_q, drv_d;
  logic [7:0] shift_q, shift_d, dbyte_q, dbyte_d;
  logic       ack_after_q, ack_after_d, dev_ack_q, dev_ack_d;
  logic [2:0] cnt_q, cnt_d, bit_q, bit_d;
  logic [1:0] ph_q, ph_d;
  logic       out_valid_q, out_valid_d;
  result_t    out_q, out_d;
  logic       go, emit, sample, last, ack_seen;
  logic [7:0] rx;

  assign go = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      drv_q       <= 1'b1;
      shift_q     <= '0;
      cnt_q       <= '0;
      bit_q       <= '0;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      drv_q       <= drv_d;
      shift_q     <= shift_d;
      cnt_q       <= cnt_d;
      bit_q       <= bit_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dbyte_q     <= dbyte_d;
    ack_after_q <= ack_after_d;
    dev_ack_q   <= dev_ack_d;
    out_q       <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    drv_d       = drv_q;
    shift_d     = shift_q;
    dbyte_d     = dbyte_q;
    ack_after_d = ack_after_q;
    dev_ack_d   = dev_ack_q;
    cnt_d       = cnt_q;
    bit_d       = bit_q;
    ph_d        = ph_q;
    cmd_pop_o   = 1'b0;
    emit        = 1'b0;
    sample      = 1'b0;
    last        = 1'b0;
    ack_seen    = 1'b0;
    rx          = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o   = 1'b1;
          ack_after_d = cmd_i.ack_after;
          dev_ack_d   = cmd_i.dev_ack;
          cnt_d       = '0;
          bit_d       = '0;
          ph_d        = '0;
          unique case (cmd_i.op)
            OP_START: state_d = ST_START;
            OP_STOP:  state_d = ST_STOP;
            OP_SEND: begin
              state_d = ST_TX_BITS;
              shift_d = cmd_i.data;
            end
            OP_RECV: begin
              state_d = ST_RX_REL;
              dbyte_d = cmd_i.data;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_START: begin
        if (go) begin
          emit  = 1'b1;
          cnt_d = cnt_q + 3'd1;
          case (cnt_q)
            3'd0:    sda_d = 1'b1;
            3'd1:    scl_d = 1'b1;
            3'd2:    sda_d = 1'b0;
            default: begin
              scl_d   = 1'b0;
              last    = 1'b1;
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_STOP: begin
        if (go) begin
          emit  = 1'b1;
          cnt_d = cnt_q + 3'd1;
          case (cnt_q)
            3'd0:    sda_d = 1'b0;
            3'd1:    scl_d = 1'b1;
            default: begin
              sda_d   = 1'b1;
              last    = 1'b1;
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_TX_BITS: begin
        if (go) begin
          emit = 1'b1;
          case (ph_q)
            2'd0: begin
              sda_d = shift_q[7];
              ph_d  = 2'd1;
            end
            2'd1: begin
              scl_d = 1'b1;
              ph_d  = 2'd2;
            end
            default: begin
              scl_d   = 1'b0;
              shift_d = {shift_q[6:0], 1'b0};
              ph_d    = 2'd0;
              if (bit_q == 3'd7) begin
                state_d = ST_TX_ACK;
                cnt_d   = '0;
              end else begin
                bit_d = bit_q + 3'd1;
              end
            end
          endcase
        end
      end

      ST_TX_ACK: begin
        if (go) begin
          emit  = 1'b1;
          cnt_d = cnt_q + 3'd1;
          case (cnt_q)
            3'd0: sda_d = 1'b1;
            3'd1: drv_d = 1'b0;
            3'd2: begin
              scl_d  = 1'b1;
              sample = 1'b1;
            end
            3'd3: drv_d = 1'b1;
            default: begin
              scl_d    = 1'b0;
              last     = 1'b1;
              ack_seen = dev_ack_q;
              state_d  = ST_IDLE;
            end
          endcase
        end
      end

      ST_RX_REL: begin
        if (go) begin
          emit    = 1'b1;
          drv_d   = 1'b0;
          shift_d = '0;
          bit_d   = '0;
          ph_d    = '0;
          state_d = ST_RX_BITS;
        end
      end

      ST_RX_BITS: begin
        if (go) begin
          emit = 1'b1;
          case (ph_q)
            2'd0: begin
              scl_d   = 1'b1;
              sample  = 1'b1;
              shift_d = {shift_q[6:0], dbyte_q[7]};
              dbyte_d = {dbyte_q[6:0], 1'b0};
              ph_d    = 2'd1;
            end
            default: begin
              scl_d = 1'b0;
              ph_d  = 2'd0;
              if (bit_q == 3'd7) begin
                state_d = ST_RX_TAIL;
                cnt_d   = '0;
              end else begin
                bit_d = bit_q + 3'd1;
              end
            end
          endcase
        end
      end

      ST_RX_TAIL: begin
        if (go) begin
          emit  = 1'b1;
          cnt_d = cnt_q + 3'd1;
          case (cnt_q)
            3'd0: drv_d = 1'b1;
            3'd1: sda_d = ~ack_after_q;
            3'd2: scl_d = 1'b1;
            3'd3: begin
              scl_d = 1'b0;
              // nack ends here: no trailing clock
              if (!ack_after_q) begin
                last    = 1'b1;
                state_d = ST_IDLE;
              end
            end
            default: begin
              sda_d   = 1'b1;
              last    = 1'b1;
              state_d = ST_IDLE;
            end
          endcase
          if (last) begin
            rx = shift_q;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase

    out_d = out_q;
    if (emit) begin
      out_d.scl_level    = scl_d;
      out_d.sda_level    = sda_d;
      out_d.sda_drive    = drv_d;
      out_d.sample_taken = sample;
      out_d.rx_data      = rx;
      out_d.ack_seen     = ack_seen;
      out_d.last         = last;
    end
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: src/i2c_master_bus_sequencer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bus_sequencer_core
// Bit-banged I2C master: expands bus primitives into per-write pin states.
// ----------------------------------------------------------------------------
// Each accepted transaction carries one bus primitive (start, stop, send byte,
// receive byte, device write or read address). It comes back as a stream of
// result transactions, one per pin write, giving SCL, SDA, SDA drive and a
// sample flag; the final one is marked last and carries the received byte or
// the sampled ack level. Undefined function codes are accepted and dropped.
// The back-end sequencer dispatches each primitive in its idle state without
// a pin write, then makes one pin write per cycle as long as the result side
// keeps taking transactions. A two-deep command queue lets the input side
// accept up to two primitives ahead of the one in progress. device_select is
// sampled when a primitive is accepted.
module i2c_master_bus_sequencer_core import i2cms_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // primitive channel
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire item_t              in_data_i,
  // pin-write result channel
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      result_t            out_data_o,
  // device select register write
  input  wire logic               cfg_we_i,
  input  wire logic [DevSelW-1:0] cfg_data_i
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Front end: accept, classify, resolve address bytes, queue
  i2cms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back end: step the pins, one write per cycle while the result side takes them, into the output register
  i2cms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Sampling only happens on a clock-high step with SDA released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.sample_taken |->
      out_data_o.scl_level && !out_data_o.sda_drive)
    else $error("sample taken outside a released clock-high step");

  // Received byte and ack level appear only on the final pin write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |->
      out_data_o.rx_data == 8'h00 && !out_data_o.ack_seen)
    else $error("status fields set on a non-final pin write");

  // Never pop the command queue while it is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command queue popped while empty");

endmodule

`default_nettype wire
